### rtl/qidr_pkg.sv
// ============================================================================
// qidr_pkg - query id remap table shared definitions
// Table geometry, operation and status codes, entry layout, sequencer states.
// ============================================================================
package qidr_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int PTR_W       = $clog2(TABLE_DEPTH);
    localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
    localparam int REMOVED_W   = 7;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_START_ID = CFG_IDX_W'(1);

    localparam logic [15:0] TIMEOUT_RST  = 16'd10;
    localparam logic [15:0] START_ID_RST = 16'd0;

    localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(TABLE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_DEPTH = FILL_W'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_SEARCH,
        OP_DELETE,
        OP_CLEAN
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_NOT_FOUND,
        STAT_FULL
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_SCAN_ADDR,
        S_SCAN_CHECK,
        S_RECLAIM,
        S_CLEAN_ADDR,
        S_CLEAN_CHECK
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_mode_t;

    // one table entry as held in the slot memory
    typedef struct packed {
        logic [15:0] issued_id;
        logic [15:0] orig_id;
        logic [31:0] addr;
        logic [15:0] port;
        logic [15:0] ctx;
        logic [31:0] expiry;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // configuration handed from the register file to the sequencer
    typedef struct packed {
        logic [15:0] timeout;
        logic        seed_load;
        logic [15:0] seed;
    } cfg_t;

    function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

### rtl/qidr_ram.sv
// ============================================================================
// qidr_ram - generic single write port RAM
// One write and one read port, read data registered.
// ============================================================================
module qidr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/qidr_addsub.sv
// ============================================================================
// qidr_addsub - shared 32-bit add / subtract unit
// Expiry sum on insert, id match and expiry compare during scans.
// ============================================================================
module qidr_addsub (
    input  qidr_pkg::alu_mode_t mode,
    input  logic [31:0]         a,
    input  logic [31:0]         b,
    output logic [32:0]         sum
);
    import qidr_pkg::*;

    logic [31:0] b_eff;
    logic        cin;

    always_comb
    begin
        b_eff = (mode == ALU_SUB) ? ~b : b;
        cin   = (mode == ALU_SUB);
    end

    // for subtract, sum[32] set means a >= b
    assign sum = {1'b0, a} + {1'b0, b_eff} + {32'd0, cin};

endmodule

### rtl/qidr_ctrl.sv
// ============================================================================
// qidr_ctrl - remap table sequencer
// Ring pointers, live bits, slot memory and scan control around one adder.
// ============================================================================
module qidr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            op,
    input  logic [15:0]           orig_id,
    input  logic [31:0]           src_addr,
    input  logic [15:0]           src_port,
    input  logic [15:0]           ctx_tag,
    input  logic [15:0]           lookup_id,
    input  logic [31:0]           now,
    input  qidr_pkg::cfg_t        cfg,
    output logic                  busy,
    output logic                  done,
    output logic [1:0]            status,
    output logic [15:0]           issued_id,
    output logic [15:0]           found_orig_id,
    output logic [31:0]           found_addr,
    output logic [15:0]           found_port,
    output logic [15:0]           found_ctx,
    output logic [6:0]            removed
);
    import qidr_pkg::*;

    state_t                 state_reg, state_next;
    logic [TABLE_DEPTH-1:0] live_reg, live_next;
    logic [PTR_W-1:0]       head_reg, head_next;
    logic [PTR_W-1:0]       tail_reg, tail_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [15:0]            last_reg, last_next;

    // latched item
    op_t                    op_reg, op_next;
    logic [15:0]            orig_reg, orig_next;
    logic [31:0]            addr_reg, addr_next;
    logic [15:0]            port_reg, port_next;
    logic [15:0]            ctx_reg, ctx_next;
    logic [15:0]            look_reg, look_next;
    logic [31:0]            now_reg, now_next;

    // scan state
    logic [PTR_W-1:0]       pos_reg, pos_next;
    logic [FILL_W-1:0]      scan_reg, scan_next;
    logic [REMOVED_W-1:0]   rem_reg, rem_next;

    // result
    logic                   done_reg, done_next;
    status_t                res_status_reg, res_status_next;
    entry_t                 res_reg, res_next;
    logic [REMOVED_W-1:0]   res_rem_reg, res_rem_next;

    // memory and shared unit
    logic                   ram_we, ram_re;
    logic [PTR_W-1:0]       ram_raddr;
    entry_t                 ram_wdata, rd_entry;
    logic [ENTRY_W-1:0]     ram_rdata;
    alu_mode_t              alu_mode;
    logic [31:0]            alu_a, alu_b;
    logic [32:0]            alu_sum;
    logic                   id_match, expired;
    logic [31:0]            expiry_sat;
    op_t                    op_in;

    qidr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    qidr_addsub u_alu (
        .mode (alu_mode),
        .a    (alu_a),
        .b    (alu_b),
        .sum  (alu_sum)
    );

    assign rd_entry   = entry_t'(ram_rdata);
    assign op_in      = op_t'(op);
    assign id_match   = (alu_sum[31:0] == 32'd0);
    assign expired    = alu_sum[32];
    assign expiry_sat = alu_sum[32] ? '1 : alu_sum[31:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (op_in)
                        OP_INSERT:
                            state_next = (fill_reg >= FILL_DEPTH) ? S_IDLE : S_INSERT;
                        OP_SEARCH, OP_DELETE:
                            state_next = S_SCAN_ADDR;
                        OP_CLEAN:
                            state_next = S_CLEAN_ADDR;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_INSERT:
                state_next = S_IDLE;
            S_SCAN_ADDR:
            begin
                if (scan_reg == fill_reg)
                    state_next = S_IDLE;
                else if (live_reg[pos_reg])
                    state_next = S_SCAN_CHECK;
            end
            S_SCAN_CHECK:
            begin
                if (id_match)
                    state_next = (op_reg == OP_DELETE) ? S_RECLAIM : S_IDLE;
                else
                    state_next = S_SCAN_ADDR;
            end
            S_RECLAIM:
            begin
                if (fill_reg == '0 || live_reg[head_reg])
                    state_next = S_IDLE;
            end
            S_CLEAN_ADDR:
            begin
                if (fill_reg == '0)
                    state_next = S_IDLE;
                else if (live_reg[head_reg])
                    state_next = S_CLEAN_CHECK;
            end
            S_CLEAN_CHECK:
                state_next = expired ? S_CLEAN_ADDR : S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        live_next       = live_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        last_next       = last_reg;
        op_next         = op_reg;
        orig_next       = orig_reg;
        addr_next       = addr_reg;
        port_next       = port_reg;
        ctx_next        = ctx_reg;
        look_next       = look_reg;
        now_next        = now_reg;
        pos_next        = pos_reg;
        scan_next       = scan_reg;
        rem_next        = rem_reg;
        done_next       = 1'b0;
        res_status_next = res_status_reg;
        res_next        = res_reg;
        res_rem_next    = res_rem_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = pos_reg;
        alu_mode        = ALU_ADD;
        alu_a           = now_reg;
        alu_b           = {16'd0, cfg.timeout};

        ram_wdata.issued_id = last_reg + 16'd1;
        ram_wdata.orig_id   = orig_reg;
        ram_wdata.addr      = addr_reg;
        ram_wdata.port      = port_reg;
        ram_wdata.ctx       = ctx_reg;
        ram_wdata.expiry    = expiry_sat;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = op_in;
                    orig_next = orig_id;
                    addr_next = src_addr;
                    port_next = src_port;
                    ctx_next  = ctx_tag;
                    look_next = lookup_id;
                    now_next  = now;
                    pos_next  = head_reg;
                    scan_next = '0;
                    rem_next  = '0;
                    if (op_in == OP_INSERT && fill_reg >= FILL_DEPTH)
                    begin
                        res_status_next = STAT_FULL;
                        res_next        = '0;
                        res_rem_next    = '0;
                        done_next       = 1'b1;
                    end
                end
            end
            S_INSERT:
            begin
                ram_we             = 1'b1;
                live_next[tail_reg] = 1'b1;
                tail_next          = next_pos(tail_reg);
                fill_next          = fill_reg + FILL_W'(1);
                last_next          = last_reg + 16'd1;
                res_status_next    = STAT_OK;
                res_next           = ram_wdata;
                res_rem_next       = '0;
                done_next          = 1'b1;
            end
            S_SCAN_ADDR:
            begin
                if (scan_reg == fill_reg)
                begin
                    res_status_next = STAT_NOT_FOUND;
                    res_next        = '0;
                    res_rem_next    = '0;
                    done_next       = 1'b1;
                end
                else if (live_reg[pos_reg])
                begin
                    ram_re = 1'b1;
                end
                else
                begin
                    pos_next  = next_pos(pos_reg);
                    scan_next = scan_reg + FILL_W'(1);
                end
            end
            S_SCAN_CHECK:
            begin
                alu_mode = ALU_SUB;
                alu_a    = {16'd0, look_reg};
                alu_b    = {16'd0, rd_entry.issued_id};
                if (id_match)
                begin
                    res_status_next = STAT_OK;
                    res_next        = rd_entry;
                    res_rem_next    = '0;
                    if (op_reg == OP_DELETE)
                        live_next[pos_reg] = 1'b0;
                    else
                        done_next = 1'b1;
                end
                else
                begin
                    pos_next  = next_pos(pos_reg);
                    scan_next = scan_reg + FILL_W'(1);
                end
            end
            S_RECLAIM:
            begin
                if (fill_reg != '0 && !live_reg[head_reg])
                begin
                    head_next = next_pos(head_reg);
                    fill_next = fill_reg - FILL_W'(1);
                end
                else
                begin
                    done_next = 1'b1;
                end
            end
            S_CLEAN_ADDR:
            begin
                ram_raddr = head_reg;
                if (fill_reg == '0)
                begin
                    res_status_next = STAT_OK;
                    res_next        = '0;
                    res_rem_next    = rem_reg;
                    done_next       = 1'b1;
                end
                else if (live_reg[head_reg])
                begin
                    ram_re = 1'b1;
                end
                else
                begin
                    head_next = next_pos(head_reg);
                    fill_next = fill_reg - FILL_W'(1);
                end
            end
            S_CLEAN_CHECK:
            begin
                alu_mode = ALU_SUB;
                alu_a    = now_reg;
                alu_b    = rd_entry.expiry;
                if (expired)
                begin
                    rem_next            = rem_reg + REMOVED_W'(1);
                    live_next[head_reg] = 1'b0;
                    head_next           = next_pos(head_reg);
                    fill_next           = fill_reg - FILL_W'(1);
                end
                else
                begin
                    res_status_next = STAT_OK;
                    res_next        = '0;
                    res_rem_next    = rem_reg;
                    done_next       = 1'b1;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase

        // seed write only arrives while idle
        if (cfg.seed_load)
            last_next = cfg.seed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            live_reg  <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            fill_reg  <= '0;
            last_reg  <= START_ID_RST;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            live_reg  <= live_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            fill_reg  <= fill_next;
            last_reg  <= last_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        orig_reg       <= orig_next;
        addr_reg       <= addr_next;
        port_reg       <= port_next;
        ctx_reg        <= ctx_next;
        look_reg       <= look_next;
        now_reg        <= now_next;
        pos_reg        <= pos_next;
        scan_reg       <= scan_next;
        rem_reg        <= rem_next;
        res_status_reg <= res_status_next;
        res_reg        <= res_next;
        res_rem_reg    <= res_rem_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = res_status_reg;
    assign issued_id     = res_reg.issued_id;
    assign found_orig_id = res_reg.orig_id;
    assign found_addr    = res_reg.addr;
    assign found_port    = res_reg.port;
    assign found_ctx     = res_reg.ctx;
    assign removed       = res_rem_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_DEPTH)
        else $error("ring fill above table depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty ring with head and tail apart");

    a_empty_live: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) |-> (live_reg == '0))
        else $error("live slot in an empty ring");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while sequencer busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op_in != OP_INSERT) |=> busy)
        else $error("scan item accepted without going busy");
`endif

endmodule

### rtl/query_id_remap_table_top.sv
// ============================================================================
// query_id_remap_table_top - query id remap table
// Issues new query ids, stores the client entry in an insertion ordered ring,
// and finds, deletes and ages out entries by scanning from the oldest slot.
// ============================================================================
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+----------------------------------------
//  item in   | start, busy (take: !busy) | op, orig_id, src_addr, src_port,
//            |                           | ctx_tag, lookup_id, now
//  result    | done strobe, one cycle    | status, issued_id, found_orig_id,
//            |                           | found_addr, found_port, found_ctx, removed
//  config    | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
//  One item at a time; busy stays high until its result is strobed. An insert
//  into a full table is answered with STAT_FULL without going busy.
//  Search and delete walk the ring from the oldest entry, skipping holes and
//  reading each live slot before comparing its issued id; a delete hit then
//  reclaims the dead slots at the oldest end of the ring. Clean examines live
//  entries from the oldest and stops at the first one not yet expired or when
//  the ring empties. The single slot memory read port and the shared adder
//  let only one slot be handled per pass.
//  Reset clears the live bits and ring pointers at once; no clearing pass.
//  The result is shown for one cycle only; the receiver cannot stall it.
//  Config writes are taken while no item is in flight.
//
module query_id_remap_table_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // item in
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     op,
    input  logic [15:0]                    orig_id,
    input  logic [31:0]                    src_addr,
    input  logic [15:0]                    src_port,
    input  logic [15:0]                    ctx_tag,
    input  logic [15:0]                    lookup_id,
    input  logic [31:0]                    now,
    // result
    output logic                           done,
    output logic [1:0]                     status,
    output logic [15:0]                    issued_id,
    output logic [15:0]                    found_orig_id,
    output logic [31:0]                    found_addr,
    output logic [15:0]                    found_port,
    output logic [15:0]                    found_ctx,
    output logic [6:0]                     removed,
    // config
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [qidr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data
);
    import qidr_pkg::*;

    logic [15:0] timeout_reg, timeout_next;
    logic        cfg_wr;
    cfg_t        cfg;

    // config writes are held off while an item is in flight
    assign cfg_ready = !busy;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb
    begin
        timeout_next = timeout_reg;
        if (cfg_wr && cfg_index == CFG_TIMEOUT)
            timeout_next = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= TIMEOUT_RST;
        else
            timeout_reg <= timeout_next;
    end

    // a seed write reloads the last issued id directly in the sequencer
    always_comb
    begin
        cfg.timeout   = timeout_reg;
        cfg.seed_load = cfg_wr && (cfg_index == CFG_START_ID);
        cfg.seed      = cfg_data;
    end

    qidr_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .op            (op),
        .orig_id       (orig_id),
        .src_addr      (src_addr),
        .src_port      (src_port),
        .ctx_tag       (ctx_tag),
        .lookup_id     (lookup_id),
        .now           (now),
        .cfg           (cfg),
        .busy          (busy),
        .done          (done),
        .status        (status),
        .issued_id     (issued_id),
        .found_orig_id (found_orig_id),
        .found_addr    (found_addr),
        .found_port    (found_port),
        .found_ctx     (found_ctx),
        .removed       (removed)
    );

endmodule
